### sv/mic_pkg.sv
// Shared types and constants for the magnetometer iron calibration block.
// No dependencies; imported by every module of the block.
package mic_pkg;

	localparam int COEF_FRAC_BITS_DEF = 14;
	localparam int COEF_W  = 16;
	localparam int SAMP_W  = 16;
	localparam int DIFF_W  = 17;
	localparam int PROD_W  = COEF_W + DIFF_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int OUT_W   = 20;
	localparam int ROW_W   = 3 * COEF_W;
	localparam int AXES    = 3;
	localparam int CFG_IDX_W = 3;

	localparam int OUT_MAX = 524287;
	localparam int OUT_MIN = -524288;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z    = 3'd5;

	typedef struct packed {
		logic [7:0] x_low_byte;
		logic [7:0] x_high_byte;
		logic [7:0] y_low_byte;
		logic [7:0] y_high_byte;
		logic [7:0] z_low_byte;
		logic [7:0] z_high_byte;
	} mic_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] field_x;
		logic signed [OUT_W-1:0] field_y;
		logic signed [OUT_W-1:0] field_z;
		logic                    saturated;
	} mic_out_t;

	// calibration set seen by the datapath; index 0 is x
	typedef struct packed {
		logic [AXES-1:0][SAMP_W-1:0] offset;
		logic [AXES-1:0][ROW_W-1:0]  row;
	} mic_cfg_t;

endpackage

### sv/mic_cfg_regs.sv
// Calibration register file: hard-iron offsets and soft-iron matrix rows.
// Depends on mic_pkg.
module mic_cfg_regs import mic_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [ROW_W-1:0]     wr_data,
	output mic_cfg_t             cfg
);

	localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << COEF_FRAC_BITS;

	mic_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset <= '0;
			cfg_q.row[0] <= {{(2*COEF_W){1'b0}}, ONE};
			cfg_q.row[1] <= {{COEF_W{1'b0}}, ONE, {COEF_W{1'b0}}};
			cfg_q.row[2] <= {ONE, {(2*COEF_W){1'b0}}};
		end else if (wr_en) begin
			case (wr_index)
				REG_OFFSET_X: cfg_q.offset[0] <= wr_data[SAMP_W-1:0];
				REG_OFFSET_Y: cfg_q.offset[1] <= wr_data[SAMP_W-1:0];
				REG_OFFSET_Z: cfg_q.offset[2] <= wr_data[SAMP_W-1:0];
				REG_ROW_X:    cfg_q.row[0] <= wr_data;
				REG_ROW_Y:    cfg_q.row[1] <= wr_data;
				REG_ROW_Z:    cfg_q.row[2] <= wr_data;
				default:      ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/mic_mac.sv
// Offset subtract and matrix multiply-accumulate, three pipeline stages.
// Depends on mic_pkg; output is the rounding-biased accumulator per axis.
module mic_mac import mic_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  mic_in_t                      in_word,
	input  mic_cfg_t                     cfg,
	output logic                         acc_valid,
	output logic signed [AXES-1:0][ACC_W-1:0] acc
);

	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	logic                           valid_s1, valid_s2, valid_s3;
	logic signed [DIFF_W-1:0]       d_s1    [AXES];
	logic signed [PROD_W-1:0]       prod_s2 [AXES][AXES];
	logic signed [AXES-1:0][ACC_W-1:0] acc_s3;

	logic signed [SAMP_W-1:0]       samp    [AXES];

	assign samp[0] = {in_word.x_high_byte, in_word.x_low_byte};
	assign samp[1] = {in_word.y_high_byte, in_word.y_low_byte};
	assign samp[2] = {in_word.z_high_byte, in_word.z_low_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// s1: difference is exact in 17 bits
	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			d_s1[a] <= DIFF_W'(samp[a]) - DIFF_W'($signed(cfg.offset[a]));
		end
	end

	// s2: nine 16x17 products
	always_ff @(posedge clk) begin
		for (int r = 0; r < AXES; r++) begin
			for (int k = 0; k < AXES; k++) begin
				prod_s2[r][k] <= PROD_W'($signed(cfg.row[r][k*COEF_W +: COEF_W]))
					* PROD_W'(d_s1[k]);
			end
		end
	end

	// s3: row sums plus half an lsb for round to nearest
	always_ff @(posedge clk) begin
		for (int r = 0; r < AXES; r++) begin
			acc_s3[r] <= ACC_W'(prod_s2[r][0]) + ACC_W'(prod_s2[r][1])
				+ ACC_W'(prod_s2[r][2]) + RND;
		end
	end

	assign acc_valid = valid_s3;
	assign acc       = acc_s3;

endmodule

### sv/mic_sat.sv
// Final stage: scale down, clamp to 20 bits and register the result word.
// Depends on mic_pkg.
module mic_sat import mic_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              acc_valid,
	input  logic signed [AXES-1:0][ACC_W-1:0] acc,
	output logic                              done,
	output mic_out_t                          result
);

	localparam int RES_W = ACC_W - COEF_FRAC_BITS;
	localparam logic signed [RES_W-1:0] R_MAX = RES_W'(OUT_MAX);
	localparam logic signed [RES_W-1:0] R_MIN = RES_W'(OUT_MIN);

	logic signed [RES_W-1:0] r        [AXES];
	logic signed [OUT_W-1:0] clip     [AXES];
	logic        [AXES-1:0]  hit;
	logic                    valid_s4;
	mic_out_t                res_s4;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			r[a] = RES_W'($signed(acc[a]) >>> COEF_FRAC_BITS);
			if (r[a] > R_MAX) begin
				clip[a] = OUT_W'(OUT_MAX);
				hit[a]  = 1'b1;
			end else if (r[a] < R_MIN) begin
				clip[a] = OUT_W'(OUT_MIN);
				hit[a]  = 1'b1;
			end else begin
				clip[a] = r[a][OUT_W-1:0];
				hit[a]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= acc_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_s4.field_x   <= clip[0];
		res_s4.field_y   <= clip[1];
		res_s4.field_z   <= clip[2];
		res_s4.saturated <= |hit;
	end

	assign done   = valid_s4;
	assign result = res_s4;

endmodule

### sv/magnetometer_iron_calibration.sv
// Magnetometer hard/soft-iron calibration, top level.
// Depends on mic_pkg, mic_cfg_regs, mic_mac and mic_sat.
//
// Takes one six-byte burst per cycle; busy is never raised. Each word comes
// out on result with done high for one cycle, after passing the four
// register stages (offset subtract, multiply, row sum, round and clamp).
// The result side has no back-pressure, so every word must be captured in
// the cycle done is high. Calibration registers are written through the
// cfg channel, always ready, and should only be changed with no burst in
// flight.
module magnetometer_iron_calibration import mic_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  mic_in_t              sample,
	output logic                 done,
	output mic_out_t             result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data
);

	mic_cfg_t                          cfg;
	logic                              acc_valid;
	logic signed [AXES-1:0][ACC_W-1:0] acc;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	mic_cfg_regs #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mic_mac #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.in_word   (sample),
		.cfg       (cfg),
		.acc_valid (acc_valid),
		.acc       (acc)
	);

	mic_sat #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc       (acc),
		.done      (done),
		.result    (result)
	);

endmodule

### sv/mic_checker.sv
// Port-level checks for magnetometer_iron_calibration, with its bind.
// Depends on mic_pkg.
module mic_checker import mic_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input mic_out_t result,
	input logic     cfg_ready
);

	// every word taken comes out with done raised
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without a matching word");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.saturated |->
			result.field_x == OUT_W'(OUT_MAX) || result.field_x == OUT_W'(OUT_MIN) ||
			result.field_y == OUT_W'(OUT_MAX) || result.field_y == OUT_W'(OUT_MIN) ||
			result.field_z == OUT_W'(OUT_MAX) || result.field_z == OUT_W'(OUT_MIN))
		else $error("saturation flag with no axis at a limit");

	a_always_open: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("pipeline should never refuse a word");

endmodule

bind magnetometer_iron_calibration mic_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.result    (result),
	.cfg_ready (cfg_ready)
);
